/* rtl/triangle_tangent_vector_defines.svh */
// Assertion macros of the triangle tangent RTL.
`ifndef TRIANGLE_TANGENT_VECTOR_DEFINES_SVH
`define TRIANGLE_TANGENT_VECTOR_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define TTV_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define TTV_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ttv_pkg.sv */
// Shared constants and types of the triangle tangent block.
package ttv_pkg;

   // digit width of the serial multiplier
   localparam int DIGIT_W = 16;
   // normalized magnitudes lie in [2^NORM_LO, 2^NORM_HI)
   localparam int NORM_HI = 30;
   localparam int NORM_LO = 29;
   // coarse step of the normalizing shifter
   localparam int NORM_STEP = 8;
   // sum of squares and square root word
   localparam int SUMSQ_W = 64;
   localparam int ROOT_STEPS = 32;

   typedef struct packed {
      logic full;
      logic empty;
   } ttv_qstat_type;

endpackage

/* rtl/ttv_if.sv */
// Request and response channel interfaces of the triangle tangent block.
interface ttv_req_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [COORD_WIDTH-1:0] tex_u;
   logic signed [COORD_WIDTH-1:0] tex_v;

   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttv_rsp_if #(
   parameter int TANGENT_WIDTH = 16
) ();
   logic                            valid;
   logic                            ready;
   logic signed [TANGENT_WIDTH-1:0] tangent_x;
   logic signed [TANGENT_WIDTH-1:0] tangent_y;
   logic signed [TANGENT_WIDTH-1:0] tangent_z;
   logic                            degenerate;

   modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
   modport sink (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

/* rtl/ttv_front.sv */
// Corner collector: holds two corners and forms edge and texture deltas on the third.
module ttv_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   ttv_req_if.sink                         req_if,
   input  ttv_pkg::ttv_qstat_type          q_stat,
   output logic                            q_push,
   output logic [10*(COORD_WIDTH+1)-1:0]   q_data
);
   localparam int DW = COORD_WIDTH + 1;

   logic [1:0] count_ff, count_in;
   logic signed [COORD_WIDTH-1:0] pos_ff [2][3];
   logic signed [COORD_WIDTH-1:0] tex_ff [2][2];
   logic third;
   logic take;
   logic signed [DW-1:0] e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2;

   assign third = (count_ff == 2'd2);
   // stall the third corner only when the queue has no room
   assign req_if.ready = !third || !q_stat.full;
   assign take = req_if.valid && req_if.ready;
   assign q_push = take && third;

   always_comb begin
      count_in = count_ff;
      if (take) begin
         count_in = third ? 2'd0 : count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !third) begin
         pos_ff[count_ff[0]][0] <= req_if.pos_x;
         pos_ff[count_ff[0]][1] <= req_if.pos_y;
         pos_ff[count_ff[0]][2] <= req_if.pos_z;
         tex_ff[count_ff[0]][0] <= req_if.tex_u;
         tex_ff[count_ff[0]][1] <= req_if.tex_v;
      end
   end

   assign e1x = DW'(pos_ff[1][0]) - DW'(pos_ff[0][0]);
   assign e1y = DW'(pos_ff[1][1]) - DW'(pos_ff[0][1]);
   assign e1z = DW'(pos_ff[1][2]) - DW'(pos_ff[0][2]);
   assign e2x = DW'(req_if.pos_x) - DW'(pos_ff[0][0]);
   assign e2y = DW'(req_if.pos_y) - DW'(pos_ff[0][1]);
   assign e2z = DW'(req_if.pos_z) - DW'(pos_ff[0][2]);
   assign du1 = DW'(tex_ff[1][0]) - DW'(tex_ff[0][0]);
   assign dv1 = DW'(tex_ff[1][1]) - DW'(tex_ff[0][1]);
   assign du2 = DW'(req_if.tex_u) - DW'(tex_ff[0][0]);
   assign dv2 = DW'(req_if.tex_v) - DW'(tex_ff[0][1]);

   assign q_data = {e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2};

endmodule

/* rtl/ttv_queue.sv */
// Two-entry queue between the corner collector and the tangent engine.
module ttv_queue #(
   parameter int WIDTH = 330
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output ttv_pkg::ttv_qstat_type stat
);
   logic [WIDTH-1:0] mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;

   assign stat.full  = (fill_ff == 2'd2);
   assign stat.empty = (fill_ff == 2'd0);
   assign pop_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in   = push ? !wr_ff : wr_ff;
      rd_in   = pop ? !rd_ff : rd_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* rtl/ttv_back.sv */
// Tangent engine: serial products, normalizing shift, square root and division.
module ttv_back #(
   parameter int COORD_WIDTH   = 32,
   parameter int TANGENT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ttv_pkg::ttv_qstat_type          q_stat,
   output logic                            q_pop,
   input  logic [10*(COORD_WIDTH+1)-1:0]   q_data,
   ttv_rsp_if.source                       rsp_if
);
   localparam int DW  = COORD_WIDTH + 1;
   localparam int ND  = (DW + ttv_pkg::DIGIT_W - 1) / ttv_pkg::DIGIT_W;
   localparam int KW  = $clog2(ND);
   localparam int AW  = ND * ttv_pkg::DIGIT_W + DW;
   localparam int MW  = 2 * DW;
   localparam int TWW = 2 * DW + 1;
   localparam int TW  = TANGENT_WIDTH;
   localparam int QW  = TW - 1;
   localparam int QSW = $clog2(TW - 1);
   localparam int SW  = ttv_pkg::SUMSQ_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MLOAD = 4'd1;
   localparam logic [3:0] ST_MSTEP = 4'd2;
   localparam logic [3:0] ST_MACC  = 4'd3;
   localparam logic [3:0] ST_CHECK = 4'd4;
   localparam logic [3:0] ST_NORM  = 4'd5;
   localparam logic [3:0] ST_SQ    = 4'd6;
   localparam logic [3:0] ST_ROOT  = 4'd7;
   localparam logic [3:0] ST_DLOAD = 4'd8;
   localparam logic [3:0] ST_DSTEP = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       ovalid_ff, ovalid_in;
   logic       load_out;

   logic [10*DW-1:0]      ent_ff;
   logic [2:0]            prod_ff;
   logic [DW-1:0]         ma_ff, mb_ff;
   logic                  mneg_ff;
   logic [KW-1:0]         dig_ff;
   logic [AW-1:0]         acc_ff;
   logic signed [TWW-1:0] det_ff;
   logic signed [TWW-1:0] t_ff [3];
   logic [MW-1:0]         mag_ff [3];
   logic                  tneg_ff [3];
   logic [1:0]            idx_ff;
   logic [SW-1:0]         rx_ff, rres_ff;
   logic [4:0]            rstep_ff;
   logic [SW-1:0]         rem_ff, dd_ff;
   logic [QW-1:0]         q_ff;
   logic [QSW-1:0]        qstep_ff;
   logic [TW-1:0]         tan_ff [3];
   logic                  degen_ff;
   logic [TW-1:0]         otan_ff [3];
   logic                  odegen_ff;

   logic signed [DW-1:0] e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2;
   logic signed [DW-1:0] op_a, op_b;
   logic                 op_sub;
   logic [DW-1:0]        abs_a, abs_b;
   logic [ND*ttv_pkg::DIGIT_W-1:0] mb_pad;
   logic [ttv_pkg::DIGIT_W-1:0]    digit;
   logic [DW+ttv_pkg::DIGIT_W-1:0] part;
   logic signed [TWW-1:0] term;
   logic [MW-1:0]        mag_or;
   logic                 hi_coarse, hi_fine, lo_fine, lo_coarse;
   logic [ttv_pkg::NORM_HI-1:0] cval;
   logic [2*ttv_pkg::NORM_HI-1:0] csq;
   logic [SW-1:0]        rbit, rtrial;
   logic                 dfit;
   logic [QW-1:0]        q_next;
   logic [TW-1:0]        qext;
   logic                 all_zero;

   assign {e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2} = ent_ff;

   // operand pair of each product and whether it is subtracted
   always_comb begin
      unique case (prod_ff)
         3'd0: begin op_a = du1; op_b = dv2; op_sub = 1'b0; end
         3'd1: begin op_a = du2; op_b = dv1; op_sub = 1'b1; end
         3'd2: begin op_a = dv2; op_b = e1x; op_sub = 1'b0; end
         3'd3: begin op_a = dv1; op_b = e2x; op_sub = 1'b1; end
         3'd4: begin op_a = dv2; op_b = e1y; op_sub = 1'b0; end
         3'd5: begin op_a = dv1; op_b = e2y; op_sub = 1'b1; end
         3'd6: begin op_a = dv2; op_b = e1z; op_sub = 1'b0; end
         default: begin op_a = dv1; op_b = e2z; op_sub = 1'b1; end
      endcase
   end

   assign abs_a  = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
   assign abs_b  = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
   assign mb_pad = (ND*ttv_pkg::DIGIT_W)'(mb_ff);
   assign digit  = mb_pad[dig_ff*ttv_pkg::DIGIT_W +: ttv_pkg::DIGIT_W];
   assign part   = ma_ff * digit;
   assign term   = TWW'(acc_ff[MW-1:0]);

   assign mag_or    = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign hi_coarse = |(mag_or >> (ttv_pkg::NORM_HI + ttv_pkg::NORM_STEP));
   assign hi_fine   = |(mag_or >> ttv_pkg::NORM_HI);
   assign lo_fine   = |(mag_or >> ttv_pkg::NORM_LO);
   assign lo_coarse = |(mag_or >> (ttv_pkg::NORM_LO - ttv_pkg::NORM_STEP));

   assign cval = mag_ff[idx_ff][ttv_pkg::NORM_HI-1:0];
   assign csq  = cval * cval;

   assign rbit   = SW'(1) << {rstep_ff, 1'b0};
   assign rtrial = rres_ff + rbit;

   assign dfit   = (rem_ff >= dd_ff);
   assign q_next = {q_ff[QW-2:0], dfit};
   assign qext   = TW'(q_next);

   assign all_zero = (t_ff[0] == '0) && (t_ff[1] == '0) && (t_ff[2] == '0);

   assign q_pop    = (state_ff == ST_IDLE) && !q_stat.empty;
   assign load_out = (state_ff == ST_OUT) && (!ovalid_ff || rsp_if.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!q_stat.empty) state_in = ST_MLOAD;
         ST_MLOAD: state_in = ST_MSTEP;
         ST_MSTEP: if (dig_ff == '0) state_in = ST_MACC;
         ST_MACC:  state_in = (prod_ff == 3'd7) ? ST_CHECK : ST_MLOAD;
         ST_CHECK: state_in = (det_ff == '0 || all_zero) ? ST_OUT : ST_NORM;
         ST_NORM:  if (!hi_fine && lo_fine) state_in = ST_SQ;
         ST_SQ:    if (idx_ff == 2'd2) state_in = ST_ROOT;
         ST_ROOT:  if (rstep_ff == 5'd0) state_in = ST_DLOAD;
         ST_DLOAD: state_in = ST_DSTEP;
         ST_DSTEP: if (qstep_ff == '0) state_in = (idx_ff == 2'd2) ? ST_OUT : ST_DLOAD;
         ST_OUT:   if (load_out) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      if (load_out) begin
         ovalid_in = 1'b1;
      end else if (rsp_if.ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            ent_ff  <= q_data;
            prod_ff <= 3'd0;
            det_ff  <= '0;
            t_ff[0] <= '0;
            t_ff[1] <= '0;
            t_ff[2] <= '0;
         end
         ST_MLOAD: begin
            ma_ff   <= abs_a;
            mb_ff   <= abs_b;
            mneg_ff <= op_a[DW-1] ^ op_b[DW-1] ^ op_sub;
            dig_ff  <= KW'(ND - 1);
            acc_ff  <= '0;
         end
         ST_MSTEP: begin
            acc_ff <= (acc_ff << ttv_pkg::DIGIT_W) + AW'(part);
            dig_ff <= dig_ff - KW'(1);
         end
         ST_MACC: begin
            if (prod_ff[2:1] == 2'd0) begin
               det_ff <= mneg_ff ? det_ff - term : det_ff + term;
            end else begin
               t_ff[prod_ff[2:1] - 2'd1] <= mneg_ff ? t_ff[prod_ff[2:1] - 2'd1] - term
                                                    : t_ff[prod_ff[2:1] - 2'd1] + term;
            end
            prod_ff <= prod_ff + 3'd1;
         end
         ST_CHECK: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i]  <= t_ff[i][TWW-1] ? MW'(-t_ff[i]) : MW'(t_ff[i]);
               tneg_ff[i] <= t_ff[i][TWW-1] ^ det_ff[TWW-1];
               tan_ff[i]  <= '0;
            end
            degen_ff <= (det_ff == '0) || all_zero;
            idx_ff   <= 2'd0;
            rx_ff    <= '0;
         end
         ST_NORM: begin
            // truncating right shifts compose, so coarse then fine steps match one shift
            for (int i = 0; i < 3; i++) begin
               if (hi_coarse) begin
                  mag_ff[i] <= mag_ff[i] >> ttv_pkg::NORM_STEP;
               end else if (hi_fine) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end else if (!lo_coarse) begin
                  mag_ff[i] <= mag_ff[i] << ttv_pkg::NORM_STEP;
               end else if (!lo_fine) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         ST_SQ: begin
            rx_ff    <= rx_ff + SW'(csq);
            idx_ff   <= idx_ff + 2'd1;
            rres_ff  <= '0;
            rstep_ff <= 5'(ttv_pkg::ROOT_STEPS - 1);
         end
         ST_ROOT: begin
            if (rx_ff >= rtrial) begin
               rx_ff   <= rx_ff - rtrial;
               rres_ff <= (rres_ff >> 1) + rbit;
            end else begin
               rres_ff <= rres_ff >> 1;
            end
            rstep_ff <= rstep_ff - 5'd1;
            idx_ff   <= 2'd0;
         end
         ST_DLOAD: begin
            // round half away: add half the length before dividing
            rem_ff   <= (SW'(cval) << (TW - 2)) + (rres_ff >> 1);
            dd_ff    <= rres_ff << (TW - 2);
            q_ff     <= '0;
            qstep_ff <= QSW'(TW - 2);
         end
         ST_DSTEP: begin
            if (dfit) begin
               rem_ff <= rem_ff - dd_ff;
            end
            dd_ff    <= dd_ff >> 1;
            q_ff     <= q_next;
            qstep_ff <= qstep_ff - QSW'(1);
            if (qstep_ff == '0) begin
               tan_ff[idx_ff] <= tneg_ff[idx_ff] ? TW'(-qext) : qext;
               idx_ff         <= idx_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         otan_ff[0] <= tan_ff[0];
         otan_ff[1] <= tan_ff[1];
         otan_ff[2] <= tan_ff[2];
         odegen_ff  <= degen_ff;
      end
   end

   assign rsp_if.valid      = ovalid_ff;
   assign rsp_if.tangent_x  = otan_ff[0];
   assign rsp_if.tangent_y  = otan_ff[1];
   assign rsp_if.tangent_z  = otan_ff[2];
   assign rsp_if.degenerate = odegen_ff;

endmodule

/* rtl/triangle_tangent_vector.sv */
// Per-triangle tangent unit: corner stream in, one unit tangent per triangle out.
//
// Corners arrive one request at a time; every third corner closes a triangle and
// yields one response, the first two yield none. Corners one and two are never
// stalled. The third corner is stalled only while the two-entry queue is full; it
// carries the edge and texture deltas to the tangent engine. For a regular triangle
// the engine pops the entry and runs eight serial products, each a load step,
// ceil((COORD_WIDTH+1)/16) digit steps and an accumulate step, then a check, a
// normalizing shifter moving 8 or 1 bit per cycle, the squaring of the three
// components, 32 square-root steps, and per component a load step and
// TANGENT_WIDTH-1 division steps; it then hands the result to the output register
// once that register is empty or its response is taken. A degenerate triangle goes
// from the check straight to the output register. That engine loop sets the
// sustained rate. A finished tangent waits in an output register, so the engine
// starts the next triangle while the response is held. A zero determinant or an
// all-zero tangent reports degenerate with a zero vector.
`include "triangle_tangent_vector_defines.svh"

module triangle_tangent_vector #(
   parameter int COORD_WIDTH   = 32,
   parameter int TANGENT_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   ttv_req_if.sink   req_if,
   ttv_rsp_if.source rsp_if
);
   localparam int QWIDTH = 10 * (COORD_WIDTH + 1);
   localparam logic signed [TANGENT_WIDTH-1:0] ONE = TANGENT_WIDTH'(1) << (TANGENT_WIDTH - 2);

   ttv_pkg::ttv_qstat_type q_stat;
   logic                   q_push;
   logic                   q_pop;
   logic [QWIDTH-1:0]      q_wdata;
   logic [QWIDTH-1:0]      q_rdata;

   // front end: hold corners, form deltas on the closing corner
   ttv_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   // decouple the collector from the engine
   ttv_queue #(
      .WIDTH(QWIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .stat      (q_stat)
   );

   // back end: products, normalize, root, divide, drive the response
   ttv_back #(
      .COORD_WIDTH  (COORD_WIDTH),
      .TANGENT_WIDTH(TANGENT_WIDTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .q_pop  (q_pop),
      .q_data (q_rdata),
      .rsp_if (rsp_if)
   );

   `TTV_ASSERT_IMPLIES(a_degen_zero, rsp_if.valid && rsp_if.degenerate, rsp_if.tangent_x == '0 && rsp_if.tangent_y == '0 && rsp_if.tangent_z == '0, "degenerate tangent not zero")
   `TTV_ASSERT_IMPLIES(a_unit_bound, rsp_if.valid && !rsp_if.degenerate, rsp_if.tangent_x <= ONE && rsp_if.tangent_x >= -ONE && rsp_if.tangent_y <= ONE && rsp_if.tangent_y >= -ONE, "tangent beyond one")
   `TTV_ASSERT_IMPLIES(a_no_push_full, q_push, !q_stat.full, "push into full queue")
   `TTV_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue empty after push")

endmodule

/* tb/triangle_tangent_vector_tb.sv */
// Self-checking testbench of the per-triangle tangent block.
`timescale 1ns / 100ps

module triangle_tangent_vector_tb;

   localparam int COORD_WIDTH   = 32;
   localparam int TANGENT_WIDTH = 16;
   localparam int IDLE_LIMIT    = 20000;
   localparam int DRAIN_CYCLES  = 400;
   localparam int RANDOM_TRIANGLES = 360;

   typedef logic signed [COORD_WIDTH-1:0]   coord_type;
   typedef logic signed [TANGENT_WIDTH-1:0] tcomp_type;
   typedef logic signed [127:0]             wide_type;

   typedef struct {
      coord_type pos[3];
      coord_type tex[2];
      bit        drain_first;  // hold this request until all responses are back
   } corner_type;

   typedef struct {
      tcomp_type tan[3];
      logic      degenerate;
   } tangent_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttv_req_if #(.COORD_WIDTH(COORD_WIDTH))     req_bus ();
   ttv_rsp_if #(.TANGENT_WIDTH(TANGENT_WIDTH)) rsp_bus ();

   triangle_tangent_vector #(
      .COORD_WIDTH  (COORD_WIDTH),
      .TANGENT_WIDTH(TANGENT_WIDTH)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus.sink),
      .rsp_if(rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   corner_type  pending_corners[$];
   tangent_type expected_tangents[$];
   corner_type  held_corners[2];
   int          corners_held = 0;
   bit          steady = 1'b0;      // no idling on either side while set
   bit          stimulus_done = 1'b0;
   int          failures = 0;

   // Mostly short gaps, a few long ones; none during steady stretches.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(99);
      if (steady || roll < 60) return 0;
      if (roll < 94) return $urandom_range(3, 1);
      return $urandom_range(80, 10);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root, bit_w;
      root = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > x) bit_w >>= 2;
      while (bit_w != 0) begin
         if (x >= root + bit_w) begin
            x = x - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root >>= 1;
         end
         bit_w >>= 2;
      end
      return root;
   endfunction

   // Tangent of the triangle a, b, c, normalized to Q2.(TANGENT_WIDTH-2).
   function automatic tangent_type triangle_tangent(corner_type a, corner_type b,
                                                    corner_type c);
      tangent_type r;
      wide_type    e1[3], e2[3], numer[3], mag[3];
      wide_type    du1, dv1, du2, dv2, det;
      logic [63:0] scaled[3], sumsq, root, q;
      int          maxlen, shift, n;
      r.tan = '{default: '0};
      r.degenerate = 1'b1;
      for (int i = 0; i < 3; i++) begin
         e1[i] = wide_type'(b.pos[i]) - wide_type'(a.pos[i]);
         e2[i] = wide_type'(c.pos[i]) - wide_type'(a.pos[i]);
      end
      du1 = wide_type'(b.tex[0]) - wide_type'(a.tex[0]);
      dv1 = wide_type'(b.tex[1]) - wide_type'(a.tex[1]);
      du2 = wide_type'(c.tex[0]) - wide_type'(a.tex[0]);
      dv2 = wide_type'(c.tex[1]) - wide_type'(a.tex[1]);
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) numer[i] = dv2 * e1[i] - dv1 * e2[i];
      if (det == 0 || (numer[0] == 0 && numer[1] == 0 && numer[2] == 0)) return r;
      maxlen = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = numer[i] < 0 ? -numer[i] : numer[i];
         n = 0;
         for (int k = 127; k >= 0; k--)
            if (n == 0 && mag[i][k]) n = k + 1;
         if (n > maxlen) maxlen = n;
      end
      // bring the largest magnitude into [2^29, 2^30)
      shift = maxlen - 30;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         scaled[i] = shift > 0 ? 64'(mag[i] >> shift) : 64'(mag[i] << (-shift));
         sumsq += scaled[i] * scaled[i];
      end
      root = floor_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
         q = (scaled[i] * (64'd1 << (TANGENT_WIDTH - 2)) + (root >> 1)) / root;
         r.tan[i] = ((numer[i] < 0) != (det < 0)) ? tcomp_type'(-q) : tcomp_type'(q);
      end
      r.degenerate = 1'b0;
      return r;
   endfunction

   function automatic corner_type make_corner(coord_type px, coord_type py, coord_type pz,
                                              coord_type tu, coord_type tv);
      corner_type k;
      k.pos = '{px, py, pz};
      k.tex = '{tu, tv};
      k.drain_first = 1'b0;
      return k;
   endfunction

   function automatic coord_type rand_coord(int kind);
      case (kind)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(2097152)) - 1048576);
         2: return coord_type'($signed($urandom_range(64)) - 32);
         default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      endcase
   endfunction

   // Queue one triangle; style picks the flavor of its content.
   task automatic push_random_triangle(bit drain);
      corner_type k[3];
      int         style, kind;
      style = $urandom_range(99);
      kind = $urandom_range(99) < 40 ? 0 : (style < 70 ? 1 : 2);
      for (int j = 0; j < 3; j++)
         k[j] = make_corner(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                            rand_coord(kind), rand_coord(kind));
      if (style >= 90 && style < 94) k[1].tex = k[0].tex;       // zero determinant
      else if (style >= 94 && style < 97) k[2].tex = k[0].tex;  // zero determinant
      else if (style >= 97) begin                               // zero tangent
         k[1].pos = k[0].pos;
         k[2].pos = k[0].pos;
      end
      if ($urandom_range(99) < 3) k[$urandom_range(2)].pos[$urandom_range(2)] =
         rand_coord(3);
      k[0].drain_first = drain;
      for (int j = 0; j < 3; j++) pending_corners.push_back(k[j]);
   endtask

   // Driver: advance to the next request once the current one is taken.
   int drive_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         drive_gap <= gap_length();
      end else if (!req_bus.valid || req_bus.ready) begin
         if (drive_gap > 0) begin
            drive_gap <= drive_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_corners.size() > 0 &&
                      !(pending_corners[0].drain_first &&
                        (expected_tangents.size() > 0 || req_bus.valid))) begin
            corner_type k;
            k = pending_corners.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.pos_x <= k.pos[0];
            req_bus.pos_y <= k.pos[1];
            req_bus.pos_z <= k.pos[2];
            req_bus.tex_u <= k.tex[0];
            req_bus.tex_v <= k.tex[1];
            drive_gap <= gap_length();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Predict on every accepted request; the third corner yields a response.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         corner_type k;
         k = make_corner(req_bus.pos_x, req_bus.pos_y, req_bus.pos_z,
                         req_bus.tex_u, req_bus.tex_v);
         if (corners_held < 2) begin
            held_corners[corners_held] = k;
            corners_held++;
         end else begin
            expected_tangents.push_back(
               triangle_tangent(held_corners[0], held_corners[1], k));
            corners_held = 0;
         end
      end
   end

   // Response side: random back-pressure, check each accepted response.
   int sink_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_tangents.size() == 0) begin
               $error("unexpected response");
               failures++;
            end else begin
               tangent_type w;
               w = expected_tangents.pop_front();
               if (rsp_bus.tangent_x !== w.tan[0]) begin
                  $error("tangent_x: expected %0d, got %0d", w.tan[0], rsp_bus.tangent_x);
                  failures++;
               end
               if (rsp_bus.tangent_y !== w.tan[1]) begin
                  $error("tangent_y: expected %0d, got %0d", w.tan[1], rsp_bus.tangent_y);
                  failures++;
               end
               if (rsp_bus.tangent_z !== w.tan[2]) begin
                  $error("tangent_z: expected %0d, got %0d", w.tan[2], rsp_bus.tangent_z);
                  failures++;
               end
               if (rsp_bus.degenerate !== w.degenerate) begin
                  $error("degenerate: expected %0b, got %0b", w.degenerate,
                         rsp_bus.degenerate);
                  failures++;
               end
            end
         end
         if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            sink_gap <= gap_length();
         end
      end
   end

   // Watchdog: drop the run if nothing moves for too long.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      corner_type k;
      req_bus.valid = 1'b0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.tex_u = '0;
      req_bus.tex_v = '0;
      rsp_bus.ready = 1'b0;

      // Directed: axis-aligned triangle, mirrored one with negative determinant.
      pending_corners.push_back(make_corner(0, 0, 0, 0, 0));
      pending_corners.push_back(make_corner(32'sh10000, 0, 0, 32'sh10000, 0));
      pending_corners.push_back(make_corner(0, 32'sh10000, 0, 0, 32'sh10000));
      pending_corners.push_back(make_corner(0, 0, 0, 0, 0));
      pending_corners.push_back(make_corner(0, 0, 32'sh10000, 0, 32'sh10000));
      pending_corners.push_back(make_corner(32'sh10000, 0, 0, 32'sh10000, 0));
      // Extremes of every field.
      pending_corners.push_back(make_corner(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                            32'sh80000000, 32'sh80000000));
      pending_corners.push_back(make_corner(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                            32'sh7fffffff, 32'sh80000000));
      pending_corners.push_back(make_corner(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                            32'sh80000000, 32'sh7fffffff));
      pending_corners.push_back(make_corner(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                            32'sh7fffffff, 32'sh7fffffff));
      pending_corners.push_back(make_corner(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                            32'sh80000000, 32'sh7fffffff));
      pending_corners.push_back(make_corner(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                            32'sh7fffffff, 32'sh80000000));
      // Zero determinant: all texture coordinates equal.
      pending_corners.push_back(make_corner(1, 2, 3, 5, 5));
      pending_corners.push_back(make_corner(7, 9, 4, 5, 5));
      pending_corners.push_back(make_corner(-3, 8, 1, 5, 5));
      // Zero tangent with a nonzero determinant: all positions equal.
      pending_corners.push_back(make_corner(-1, -1, -1, 0, 0));
      pending_corners.push_back(make_corner(-1, -1, -1, 1, 0));
      pending_corners.push_back(make_corner(-1, -1, -1, 0, 1));
      // Tiny deltas, one-ulp edges.
      pending_corners.push_back(make_corner(0, 0, 0, 0, 0));
      pending_corners.push_back(make_corner(1, 0, -1, 1, 0));
      pending_corners.push_back(make_corner(0, -1, 0, 0, -1));

      // Random triangles; a steady stretch and a few drain points in between.
      for (int t = 0; t < RANDOM_TRIANGLES; t++)
         push_random_triangle(t == 0 || t % 120 == 60);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_corners.size() < 3 * (RANDOM_TRIANGLES - 100));
      steady = 1'b1;
      wait (pending_corners.size() < 3 * (RANDOM_TRIANGLES - 150));
      steady = 1'b0;

      wait (pending_corners.size() == 0);
      @(posedge clock);
      while (req_bus.valid || expected_tangents.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_tangents.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
